// File: rtl/core/sphere_frustum_cull_lod_select_defines.svh
// Assertion macros for the sphere frustum cull and detail select block.
`ifndef SPHERE_FRUSTUM_CULL_LOD_SELECT_DEFINES_SVH
`define SPHERE_FRUSTUM_CULL_LOD_SELECT_DEFINES_SVH
`ifndef SYNTHESIS
`define SFC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sfc: implication check failed");
`define SFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sfc: next-cycle check failed");
`else
`define SFC_ASSERT_IMP(label, ante, cons)
`define SFC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/core/sfc_pkg.sv
// Shared types and constants for the sphere frustum cull and detail select block.
package sfc_pkg;

    localparam int NATIVE_CLIP_WIDTH_DEF = 512;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int PROD_W     = 38;
    localparam int VERT_W     = 24;
    localparam int VY_SCALE   = 32;
    localparam int VZ_SCALE   = 17;
    localparam int NEAR_LIMIT = 256;
    localparam int LOD_BIAS   = 256;

    localparam logic [14:0] CLIP_WIDTH_RST = 15'd512;
    localparam logic [15:0] LOD_DIST_RST   = 16'd0;

    localparam logic [31:0] MASK_BOTH      = 32'h0000_0000;
    localparam logic [31:0] MASK_LOW_ONLY  = 32'hffff_0000;
    localparam logic [31:0] MASK_HIGH_ONLY = 32'h0000_ffff;
    localparam logic [31:0] MASK_NONE      = 32'hffff_ffff;
    localparam logic [7:0]  BYTE_LIMIT     = 8'h80;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLIP_WIDTH   = 2'd0,
        CFG_LOD_DISTANCE = 2'd1,
        CFG_DECODING     = 2'd2
    } t_cfg_idx;

    typedef logic signed [17:0]       t_s18;
    typedef logic signed [PROD_W-1:0] t_prod;

    typedef struct packed {
        logic signed [15:0] view_x;
        logic signed [15:0] view_y;
        logic signed [15:0] view_z;
        logic [12:0]        radius;
        logic               skip_low;
        logic               skip_high;
        logic               force_low;
        logic [31:0]        current_animation;
        logic [31:0]        previous_animation;
    } t_sector;

    typedef struct packed {
        logic [14:0] view_width;
        logic [15:0] lod_distance;
        logic        decoding_animation;
    } t_cfg;

    typedef struct packed {
        t_s18               ex_b;
        t_s18               dp_b;
        t_s18               ex_i;
        t_s18               dp_i;
        t_s18               vy_b;
        t_s18               vz_b;
        t_s18               vy_i;
        t_s18               vz_i;
        t_s18               zpr;
        t_s18               zmr;
        logic signed [18:0] w3;
        logic               skip_low;
        logic               skip_high;
        logic               force_low;
        logic [31:0]        cur;
        logic [31:0]        prev;
    } t_s1;

    typedef struct packed {
        t_prod       lb;
        t_prod       rn;
        t_prod       rw;
        t_prod       li;
        t_prod       ri;
        logic        vert_b_ok;
        logic        vert_i_ok;
        logic        zpr_pos;
        logic        zmr_pos;
        logic        low;
        logic        high;
        logic        near;
        logic [31:0] cur;
        logic [31:0] prev;
    } t_s2;

    typedef struct packed {
        logic        visible;
        logic        partial;
        logic        emit_low;
        logic        emit_high;
        logic        near_tag;
        logic [31:0] active_mask;
        logic [31:0] active_word;
        logic        animation_pending;
    } t_res;

endpackage

// File: rtl/core/sfc_ifs.sv
// Handshake channel interfaces: sector input, result output and configuration writes.
interface sfc_sector_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] view_x;
    logic signed [15:0] view_y;
    logic signed [15:0] view_z;
    logic [12:0]        radius;
    logic               skip_low;
    logic               skip_high;
    logic               force_low;
    logic [31:0]        current_animation;
    logic [31:0]        previous_animation;

    modport source (
        output valid, view_x, view_y, view_z, radius, skip_low, skip_high, force_low,
               current_animation, previous_animation,
        input  ready
    );
    modport sink (
        input  valid, view_x, view_y, view_z, radius, skip_low, skip_high, force_low,
               current_animation, previous_animation,
        output ready
    );
endinterface

interface sfc_result_if;
    logic        valid;
    logic        ready;
    logic        visible;
    logic        partial;
    logic        emit_low;
    logic        emit_high;
    logic        near_tag;
    logic [31:0] active_mask;
    logic [31:0] active_word;
    logic        animation_pending;

    modport source (
        output valid, visible, partial, emit_low, emit_high, near_tag, active_mask,
               active_word, animation_pending,
        input  ready
    );
    modport sink (
        input  valid, visible, partial, emit_low, emit_high, near_tag, active_mask,
               active_word, animation_pending,
        output ready
    );
endinterface

interface sfc_cfg_if;
    import sfc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/sfc_prep.sv
// First stage: radius margins, absolute offsets and plane extent/depth terms.
module sfc_prep #(
    parameter int NATIVE_CLIP_WIDTH = sfc_pkg::NATIVE_CLIP_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  sfc_pkg::t_sector i_sector,
    input  sfc_pkg::t_cfg   i_cfg,
    output logic            o_valid,
    input  logic            i_ready,
    output sfc_pkg::t_s1    o_s1
);
    import sfc_pkg::*;

    localparam logic [14:0] NATIVE_W = 15'(NATIVE_CLIP_WIDTH);

    logic        r_valid;
    t_s1         r_s1;
    t_s1         n_s1;
    logic [12:0] hx, xz, hy, yz;
    t_s18        xs, ys, zs, rs, ax, ay;
    logic [14:0] w_eff;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_s1    = r_s1;

    always_comb begin
        hx = {1'b0, i_sector.radius[12:1]} + {2'b0, i_sector.radius[12:2]}
           + {5'b0, i_sector.radius[12:5]};
        xz = {1'b0, i_sector.radius[12:1]} + {4'b0, i_sector.radius[12:4]}
           + {5'b0, i_sector.radius[12:5]};
        hy = i_sector.radius - {3'b0, i_sector.radius[12:3]};
        yz = {1'b0, i_sector.radius[12:1]} - {4'b0, i_sector.radius[12:4]};
        xs = 18'(i_sector.view_x);
        ys = 18'(i_sector.view_y);
        zs = 18'(i_sector.view_z);
        rs = signed'({5'b0, i_sector.radius});
        ax = (xs < 0) ? -xs : xs;
        ay = (ys < 0) ? -ys : ys;
        w_eff = (i_cfg.view_width < NATIVE_W) ? NATIVE_W : i_cfg.view_width;

        n_s1.ex_b      = ax - signed'({5'b0, hx});
        n_s1.ex_i      = ax + signed'({5'b0, hx});
        n_s1.dp_b      = zs + signed'({5'b0, xz});
        n_s1.dp_i      = zs - signed'({5'b0, xz});
        n_s1.vy_b      = ay - signed'({5'b0, hy});
        n_s1.vy_i      = ay + signed'({5'b0, hy});
        n_s1.vz_b      = zs + signed'({5'b0, yz});
        n_s1.vz_i      = zs - signed'({5'b0, yz});
        n_s1.zpr       = zs + rs;
        n_s1.zmr       = zs - rs;
        n_s1.w3        = signed'({2'b0, 17'(w_eff * 3)});
        n_s1.skip_low  = i_sector.skip_low;
        n_s1.skip_high = i_sector.skip_high;
        n_s1.force_low = i_sector.force_low;
        n_s1.cur       = i_sector.current_animation;
        n_s1.prev      = i_sector.previous_animation;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_s1 <= n_s1;
        end
    end

endmodule

// File: rtl/core/sfc_mult.sv
// Second stage: side plane products, vertical plane terms and detail routing.
module sfc_mult #(
    parameter int NATIVE_CLIP_WIDTH = sfc_pkg::NATIVE_CLIP_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sfc_pkg::t_s1  i_s1,
    input  sfc_pkg::t_cfg i_cfg,
    output logic          o_valid,
    input  logic          i_ready,
    output sfc_pkg::t_s2  o_s2
);
    import sfc_pkg::*;

    localparam logic signed [14:0] K4N = 15'(4 * NATIVE_CLIP_WIDTH);
    localparam logic signed [14:0] K3N = 15'(3 * NATIVE_CLIP_WIDTH);

    logic               r_valid;
    t_s2                r_s2;
    t_s2                n_s2;
    logic signed [VERT_W-1:0] vb, vi;
    logic signed [18:0] lod_s;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_s2    = r_s2;

    always_comb begin
        vb = VERT_W'(i_s1.vy_b * VY_SCALE - i_s1.vz_b * VZ_SCALE);
        vi = VERT_W'(i_s1.vy_i * VY_SCALE - i_s1.vz_i * VZ_SCALE);
        lod_s = signed'({3'b0, i_cfg.lod_distance});

        n_s2.lb        = i_s1.ex_b * K4N;
        n_s2.rn        = i_s1.dp_b * K3N;
        n_s2.rw        = i_s1.dp_b * i_s1.w3;
        n_s2.li        = i_s1.ex_i * K4N;
        n_s2.ri        = i_s1.dp_i * i_s1.w3;
        n_s2.vert_b_ok = vb[VERT_W-1];
        n_s2.vert_i_ok = vi[VERT_W-1];
        n_s2.zpr_pos   = (i_s1.zpr > 0);
        n_s2.zmr_pos   = (i_s1.zmr > 0);
        n_s2.low       = !i_s1.skip_low && (i_s1.force_low
                       || (lod_s < 19'(i_s1.zpr) + 19'(LOD_BIAS)));
        n_s2.high      = !i_s1.skip_high && (19'(i_s1.zmr) < lod_s);
        n_s2.near      = n_s2.high && (i_s1.zmr < 18'(NEAR_LIMIT));
        n_s2.cur       = i_s1.cur;
        n_s2.prev      = i_s1.prev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_s2 <= n_s2;
        end
    end

endmodule

// File: rtl/core/sfc_class.sv
// Third stage: plane compares, visibility class, channel mask and pending check.
module sfc_class (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sfc_pkg::t_s2  i_s2,
    input  sfc_pkg::t_cfg i_cfg,
    output logic          o_valid,
    input  logic          i_ready,
    output sfc_pkg::t_res o_res
);
    import sfc_pkg::*;

    logic        r_valid;
    t_res        r_res;
    t_res        n_res;
    logic        vis, wholly_in, pend;
    logic [31:0] mask, pword;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_comb begin
        vis = i_s2.zpr_pos && ((i_s2.lb < i_s2.rn) || (i_s2.lb < i_s2.rw)) && i_s2.vert_b_ok;
        wholly_in = i_s2.zmr_pos && (i_s2.li < i_s2.ri) && i_s2.vert_i_ok;
        unique case ({i_s2.low, i_s2.high})
            2'b11:   mask = MASK_BOTH;
            2'b10:   mask = MASK_LOW_ONLY;
            2'b01:   mask = MASK_HIGH_ONLY;
            default: mask = MASK_NONE;
        endcase
        pword = i_s2.prev | mask;
        pend  = 1'b0;
        for (int b = 0; b < 4; b++) begin
            if (((i_s2.cur | mask) >> (8 * b)) % 256 < 32'(BYTE_LIMIT)
                || (pword >> (8 * b)) % 256 < 32'(BYTE_LIMIT)) begin
                pend = 1'b1;
            end
        end

        n_res = '0;
        if (vis) begin
            n_res.visible           = 1'b1;
            n_res.partial           = !wholly_in;
            n_res.emit_low          = i_s2.low;
            n_res.emit_high         = i_s2.high;
            n_res.near_tag          = i_s2.near;
            n_res.active_mask       = mask;
            n_res.active_word       = i_s2.cur | mask;
            n_res.animation_pending = pend && !i_cfg.decoding_animation;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_res <= n_res;
        end
    end

endmodule

// File: rtl/core/sphere_frustum_cull_lod_select.sv
// Sphere frustum cull and detail select, top level.
// Three register stages; a taken sector word's result is offered from the class stage register.
// Throughput: one word per cycle unless the output stalls; stages: margins, multiplies, compares.
// A stalled output holds its word while earlier stages keep filling until all are full.
// Reset (synchronous, active low) empties the pipeline and restores the registers.
`include "sphere_frustum_cull_lod_select_defines.svh"
module sphere_frustum_cull_lod_select #(
    parameter int NATIVE_CLIP_WIDTH = sfc_pkg::NATIVE_CLIP_WIDTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    sfc_sector_if.sink   i_sector,
    sfc_result_if.source o_result,
    sfc_cfg_if.sink      i_cfg
);
    import sfc_pkg::*;

    logic [14:0] r_view_width;
    logic [15:0] r_lod_distance;
    logic        r_decoding;
    t_cfg        w_cfg;
    t_sector     w_sector;
    logic        w_s1_valid, w_s1_ready, w_s2_valid, w_s2_ready;
    t_s1         w_s1;
    t_s2         w_s2;
    t_res        w_res;
    logic        w_hidden_clear;
    logic        w_word_covers;
    logic        w_near_ok;

    assign i_cfg.ready = 1'b1;
    assign w_cfg = '{view_width: r_view_width, lod_distance: r_lod_distance,
                     decoding_animation: r_decoding};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_width   <= CLIP_WIDTH_RST;
            r_lod_distance <= LOD_DIST_RST;
            r_decoding     <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_CLIP_WIDTH:   r_view_width   <= i_cfg.data[14:0];
                CFG_LOD_DISTANCE: r_lod_distance <= i_cfg.data;
                CFG_DECODING:     r_decoding     <= i_cfg.data[0];
                default:          ;
            endcase
        end
    end

    assign w_sector = '{
        view_x:             i_sector.view_x,
        view_y:             i_sector.view_y,
        view_z:             i_sector.view_z,
        radius:             i_sector.radius,
        skip_low:           i_sector.skip_low,
        skip_high:          i_sector.skip_high,
        force_low:          i_sector.force_low,
        current_animation:  i_sector.current_animation,
        previous_animation: i_sector.previous_animation
    };

    sfc_prep #(.NATIVE_CLIP_WIDTH(NATIVE_CLIP_WIDTH)) u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_sector.valid),
        .o_ready  (i_sector.ready),
        .i_sector (w_sector),
        .i_cfg    (w_cfg),
        .o_valid  (w_s1_valid),
        .i_ready  (w_s1_ready),
        .o_s1     (w_s1)
    );

    sfc_mult #(.NATIVE_CLIP_WIDTH(NATIVE_CLIP_WIDTH)) u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s1_valid),
        .o_ready (w_s1_ready),
        .i_s1    (w_s1),
        .i_cfg   (w_cfg),
        .o_valid (w_s2_valid),
        .i_ready (w_s2_ready),
        .o_s2    (w_s2)
    );

    sfc_class u_class (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s2_valid),
        .o_ready (w_s2_ready),
        .i_s2    (w_s2),
        .i_cfg   (w_cfg),
        .o_valid (o_result.valid),
        .i_ready (o_result.ready),
        .o_res   (w_res)
    );

    assign o_result.visible           = w_res.visible;
    assign o_result.partial           = w_res.partial;
    assign o_result.emit_low          = w_res.emit_low;
    assign o_result.emit_high         = w_res.emit_high;
    assign o_result.near_tag          = w_res.near_tag;
    assign o_result.active_mask       = w_res.active_mask;
    assign o_result.active_word       = w_res.active_word;
    assign o_result.animation_pending = w_res.animation_pending;

    assign w_hidden_clear = (o_result.active_mask == '0) && (o_result.active_word == '0)
                          && !o_result.animation_pending && !o_result.emit_low
                          && !o_result.emit_high;
    assign w_word_covers  = (o_result.active_word & o_result.active_mask)
                          == o_result.active_mask;
    assign w_near_ok      = o_result.emit_high && o_result.visible;

    `SFC_ASSERT_IMP(a_hidden_zero, o_result.valid && !o_result.visible, w_hidden_clear)
    `SFC_ASSERT_IMP(a_word_covers_mask, o_result.valid, w_word_covers)
    `SFC_ASSERT_IMP(a_near_needs_high, o_result.valid && o_result.near_tag, w_near_ok)
    `SFC_ASSERT_NEXT(a_accept_fills, i_sector.valid && i_sector.ready, w_s1_valid)

endmodule
